>>> hdl/hbq_pkg.sv
`timescale 1ns / 1ps
package hbq_pkg;

    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 64;

    localparam int CELL_W  = 6;
    localparam int CNT_W   = CELL_W + 1;
    localparam int RES_W   = 16;
    localparam int SMP_W   = 16;
    localparam int HGT_W   = 32;
    localparam int REM_W   = RES_W + CELL_W;
    localparam int NUM_W   = 50;
    localparam int MAG_W   = NUM_W - 1;
    localparam int QUOT_W  = HGT_W - 1;
    localparam int BANK_AW = 2 * (CELL_W - 1);
    localparam int BANK_DEPTH = 2 ** BANK_AW;

    localparam int REG_COUNT = 6;
    localparam int ADDR_W    = $clog2(REG_COUNT) + 2;
    localparam int IDX_W     = ADDR_W - 2;

    localparam logic [IDX_W-1:0] REG_XY_RES  = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_Z_RES   = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_LEFT    = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_BOTTOM  = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_COLUMNS = IDX_W'(4);
    localparam logic [IDX_W-1:0] REG_ROWS    = IDX_W'(5);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                    opcode;
        logic [CELL_W-1:0]       sample_col;
        logic [CELL_W-1:0]       sample_row;
        logic signed [SMP_W-1:0] sample_value;
        logic signed [31:0]      query_x;
        logic signed [31:0]      query_y;
    } t_in_item;

    typedef struct packed {
        logic signed [HGT_W-1:0] height;
        logic                    in_range;
    } t_out_item;

    typedef struct packed {
        logic             valid;
        logic             ok;
        logic [RES_W-1:0] frac;
    } t_div_tag;

endpackage

>>> hdl/hbq_ram.sv
`timescale 1ns / 1ps
module hbq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> hdl/hbq_div.sv
`timescale 1ns / 1ps
module hbq_div
    import hbq_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic [RES_W-1:0]        i_divisor,
    input  logic signed [NUM_W-1:0] i_num,
    input  t_div_tag                i_tag,
    output logic signed [HGT_W-1:0] o_quot,
    output t_div_tag                o_tag
);
    logic [MAG_W-1:0]  r_rem  [0:QUOT_W];
    logic [QUOT_W-1:0] r_quot [0:QUOT_W];
    logic              r_neg  [0:QUOT_W];
    t_div_tag          r_tag  [0:QUOT_W];
    logic [MAG_W-1:0]  w_dsh  [0:QUOT_W-1];
    logic signed [NUM_W-1:0] w_abs;
    logic signed [HGT_W-1:0] w_q;

    always_comb begin
        w_abs = i_num[NUM_W-1] ? -i_num : i_num;
        for (int k = 0; k < QUOT_W; k++) begin
            w_dsh[k] = MAG_W'(i_divisor) << (QUOT_W - 1 - k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QUOT_W; k++) begin
                r_tag[k] <= '0;
            end
        end else if (i_en) begin
            r_tag[0] <= i_tag;
            for (int k = 0; k < QUOT_W; k++) begin
                r_tag[k+1] <= r_tag[k];
            end
        end
    end

    // one quotient bit per stage, magnitude only
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= w_abs[MAG_W-1:0];
            r_quot[0] <= '0;
            r_neg[0]  <= i_num[NUM_W-1];
            for (int k = 0; k < QUOT_W; k++) begin
                r_neg[k+1] <= r_neg[k];
                if (r_rem[k] >= w_dsh[k]) begin
                    r_rem[k+1]  <= r_rem[k] - w_dsh[k];
                    r_quot[k+1] <= r_quot[k] | (QUOT_W'(1) << (QUOT_W - 1 - k));
                end else begin
                    r_rem[k+1]  <= r_rem[k];
                    r_quot[k+1] <= r_quot[k];
                end
            end
        end
    end

    assign w_q    = $signed({1'b0, r_quot[QUOT_W]});
    assign o_quot = r_neg[QUOT_W] ? -w_q : w_q;
    assign o_tag  = r_tag[QUOT_W];
endmodule

>>> hdl/heightfield_bilinear_height_query_unit.sv
`timescale 1ns / 1ps
// throughput: one request per cycle, writes and queries alike, unless the input is stalled,
// set by the read of the four sample banks and the fully pipelined dividers
// writes give no result; input stalls only when a finished query waits at the output
// reset: synchronous active low, registers to defaults, pipeline emptied, samples kept
module heightfield_bilinear_height_query_unit
    import hbq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    typedef struct packed {
        logic [CELL_W-1:0] col;
        logic [CELL_W-1:0] row;
        logic [SMP_W-1:0]  val;
    } t_wr;

    typedef struct packed {
        logic             valid;
        logic             ok;
        logic [RES_W-1:0] fx;
        logic [RES_W-1:0] fy;
    } t_side;

    logic [RES_W-1:0]  r_xy_res, r_z_res;
    logic [31:0]       r_map_left, r_map_bottom;
    logic [CNT_W-1:0]  r_columns, r_rows;
    logic [IDX_W-1:0]  w_idx;
    logic              w_cfg_we;
    logic [RES_W-1:0]  w_res;
    logic [CNT_W-1:0]  w_cols, w_rows;
    logic              w_en;

    assign w_idx    = paddr[ADDR_W-1:2];
    assign w_cfg_we = psel && penable && pwrite;
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xy_res     <= RES_W'(1);
            r_z_res      <= RES_W'(1);
            r_map_left   <= '0;
            r_map_bottom <= '0;
            r_columns    <= CNT_W'(64);
            r_rows       <= CNT_W'(64);
        end else if (w_cfg_we) begin
            unique case (w_idx)
                REG_XY_RES:  r_xy_res     <= pwdata[RES_W-1:0];
                REG_Z_RES:   r_z_res      <= pwdata[RES_W-1:0];
                REG_LEFT:    r_map_left   <= pwdata;
                REG_BOTTOM:  r_map_bottom <= pwdata;
                REG_COLUMNS: r_columns    <= pwdata[CNT_W-1:0];
                REG_ROWS:    r_rows       <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_XY_RES:  prdata = 32'(r_xy_res);
            REG_Z_RES:   prdata = 32'(r_z_res);
            REG_LEFT:    prdata = r_map_left;
            REG_BOTTOM:  prdata = r_map_bottom;
            REG_COLUMNS: prdata = 32'(r_columns);
            REG_ROWS:    prdata = 32'(r_rows);
            default:     prdata = '0;
        endcase
    end

    assign w_res  = (r_xy_res == '0) ? RES_W'(1) : r_xy_res;
    assign w_cols = (r_columns > CNT_W'(MAX_COLUMNS)) ? CNT_W'(MAX_COLUMNS) : r_columns;
    assign w_rows = (r_rows > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : r_rows;

    // stage a: origin subtract
    logic                r_a_valid, r_a_op;
    t_wr                 r_a_wr;
    logic signed [32:0]  r_a_xoff, r_a_yoff;

    assign o_in_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_op   <= i_in_data.opcode;
            r_a_wr   <= {i_in_data.sample_col, i_in_data.sample_row, i_in_data.sample_value};
            r_a_xoff <= {i_in_data.query_x[31], i_in_data.query_x}
                      - {r_map_left[31], r_map_left};
            r_a_yoff <= {i_in_data.query_y[31], i_in_data.query_y}
                      - {r_map_bottom[31], r_map_bottom};
        end
    end

    // cell index stages, one quotient bit each
    logic              r_dv_valid [0:CELL_W];
    logic              r_dv_op    [0:CELL_W];
    t_wr               r_dv_wr    [0:CELL_W];
    logic              r_dv_bad   [0:CELL_W];
    logic [REM_W-1:0]  r_dv_rx    [0:CELL_W];
    logic [REM_W-1:0]  r_dv_ry    [0:CELL_W];
    logic [CELL_W-1:0] r_dv_qx    [0:CELL_W];
    logic [CELL_W-1:0] r_dv_qy    [0:CELL_W];
    logic [REM_W-1:0]  w_dsh      [0:CELL_W-1];
    logic [31:0]       w_lim;
    logic              w_bad;

    always_comb begin
        w_lim = {{(32 - REM_W){1'b0}}, w_res, {CELL_W{1'b0}}};
        w_bad = r_a_xoff[32] || r_a_yoff[32]
             || (r_a_xoff[31:0] >= w_lim) || (r_a_yoff[31:0] >= w_lim);
        for (int k = 0; k < CELL_W; k++) begin
            w_dsh[k] = REM_W'(w_res) << (CELL_W - 1 - k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= CELL_W; k++) begin
                r_dv_valid[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_dv_valid[0] <= r_a_valid;
            for (int k = 0; k < CELL_W; k++) begin
                r_dv_valid[k+1] <= r_dv_valid[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_op[0]  <= r_a_op;
            r_dv_wr[0]  <= r_a_wr;
            r_dv_bad[0] <= w_bad;
            r_dv_rx[0]  <= r_a_xoff[REM_W-1:0];
            r_dv_ry[0]  <= r_a_yoff[REM_W-1:0];
            r_dv_qx[0]  <= '0;
            r_dv_qy[0]  <= '0;
            for (int k = 0; k < CELL_W; k++) begin
                r_dv_op[k+1]  <= r_dv_op[k];
                r_dv_wr[k+1]  <= r_dv_wr[k];
                r_dv_bad[k+1] <= r_dv_bad[k];
                if (r_dv_rx[k] >= w_dsh[k]) begin
                    r_dv_rx[k+1] <= r_dv_rx[k] - w_dsh[k];
                    r_dv_qx[k+1] <= r_dv_qx[k] | (CELL_W'(1) << (CELL_W - 1 - k));
                end else begin
                    r_dv_rx[k+1] <= r_dv_rx[k];
                    r_dv_qx[k+1] <= r_dv_qx[k];
                end
                if (r_dv_ry[k] >= w_dsh[k]) begin
                    r_dv_ry[k+1] <= r_dv_ry[k] - w_dsh[k];
                    r_dv_qy[k+1] <= r_dv_qy[k] | (CELL_W'(1) << (CELL_W - 1 - k));
                end else begin
                    r_dv_ry[k+1] <= r_dv_ry[k];
                    r_dv_qy[k+1] <= r_dv_qy[k];
                end
            end
        end
    end

    // stage c: range check, bank access
    logic              r_c_valid, r_c_op, r_c_ok;
    t_wr               r_c_wr;
    logic [CELL_W-1:0] r_c_qx, r_c_qy;
    logic [RES_W-1:0]  r_c_fx, r_c_fy;
    logic [CNT_W-1:0]  w_need_c, w_need_r;
    logic              w_ok;

    always_comb begin
        w_need_c = {1'b0, r_dv_qx[CELL_W]}
                 + CNT_W'(r_dv_rx[CELL_W] != '0);
        w_need_r = {1'b0, r_dv_qy[CELL_W]}
                 + CNT_W'(r_dv_ry[CELL_W] != '0);
        w_ok = !r_dv_bad[CELL_W] && (w_need_c < w_cols) && (w_need_r < w_rows);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_en) begin
            r_c_valid <= r_dv_valid[CELL_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_op <= r_dv_op[CELL_W];
            r_c_wr <= r_dv_wr[CELL_W];
            r_c_ok <= w_ok;
            r_c_qx <= r_dv_qx[CELL_W];
            r_c_qy <= r_dv_qy[CELL_W];
            r_c_fx <= r_dv_rx[CELL_W][RES_W-1:0];
            r_c_fy <= r_dv_ry[CELL_W][RES_W-1:0];
        end
    end

    logic [SMP_W-1:0] w_bank_rdata [0:3];
    logic             w_wr_inside;

    assign w_wr_inside = ({1'b0, r_c_wr.col} < CNT_W'(MAX_COLUMNS))
                      && ({1'b0, r_c_wr.row} < CNT_W'(MAX_ROWS));

    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic PX = 1'((b >> 1) & 1);
        localparam logic PY = 1'(b & 1);
        logic [CNT_W-1:0]   w_col_sel, w_row_sel;
        logic               w_we;

        assign w_col_sel = (r_c_qx[0] == PX) ? {1'b0, r_c_qx} : {1'b0, r_c_qx} + CNT_W'(1);
        assign w_row_sel = (r_c_qy[0] == PY) ? {1'b0, r_c_qy} : {1'b0, r_c_qy} + CNT_W'(1);
        assign w_we = w_en && r_c_valid && (r_c_op == OP_WRITE) && w_wr_inside
                   && (r_c_wr.col[0] == PX) && (r_c_wr.row[0] == PY);

        hbq_ram #(
            .WIDTH (SMP_W),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (w_we),
            .i_waddr ({r_c_wr.col[CELL_W-1:1], r_c_wr.row[CELL_W-1:1]}),
            .i_wdata (r_c_wr.val),
            .i_re    (w_en),
            .i_raddr ({w_col_sel[CELL_W-1:1], w_row_sel[CELL_W-1:1]}),
            .o_rdata (w_bank_rdata[b])
        );
    end

    // stage d: corner select and masking
    t_side r_d_side;
    logic  r_d_px, r_d_py;
    logic signed [SMP_W-1:0] w_corner [0:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_side <= '0;
        end else if (w_en) begin
            r_d_side <= {r_c_valid && (r_c_op == OP_QUERY), r_c_ok, r_c_fx, r_c_fy};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_px <= r_c_qx[0];
            r_d_py <= r_c_qy[0];
        end
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            if (((c >> 1) == 1 && r_d_side.fx == '0) || ((c & 1) == 1 && r_d_side.fy == '0)) begin
                w_corner[c] = '0;
            end else begin
                w_corner[c] = $signed(w_bank_rdata[{r_d_px ^ 1'((c >> 1) & 1),
                                                    r_d_py ^ 1'(c & 1)}]);
            end
        end
    end

    // stages e, f, g: vertical scale, weights, sums
    t_side r_e_side, r_f_side, r_g_side;
    logic signed [32:0]      r_e_s [0:3];
    logic signed [NUM_W-1:0] r_f_p [0:3];
    logic signed [NUM_W-1:0] r_g_num [0:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_side <= '0;
            r_f_side <= '0;
            r_g_side <= '0;
        end else if (w_en) begin
            r_e_side <= r_d_side;
            r_f_side <= r_e_side;
            r_g_side <= r_f_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 4; c++) begin
                r_e_s[c] <= w_corner[c] * $signed({1'b0, r_z_res});
            end
            for (int c = 0; c < 2; c++) begin
                r_f_p[c]   <= $signed({1'b0, w_res - r_e_side.fx}) * r_e_s[c];
                r_f_p[c+2] <= $signed({1'b0, r_e_side.fx}) * r_e_s[c+2];
            end
            for (int c = 0; c < 2; c++) begin
                r_g_num[c] <= r_f_p[c] + r_f_p[c+2];
            end
        end
    end

    // blend along x, lower and upper rows in parallel
    t_div_tag                w_g_tag, w_x_tag, w_y_tag;
    logic signed [HGT_W-1:0] w_lower, w_upper, w_height;

    assign w_g_tag = {r_g_side.valid, r_g_side.ok, r_g_side.fy};

    hbq_div u_div_lower (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_divisor (w_res),
        .i_num     (r_g_num[0]),
        .i_tag     (w_g_tag),
        .o_quot    (w_lower),
        .o_tag     (w_x_tag)
    );

    hbq_div u_div_upper (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_divisor (w_res),
        .i_num     (r_g_num[1]),
        .i_tag     (w_g_tag),
        .o_quot    (w_upper),
        .o_tag     ()
    );

    // blend along y
    logic                    r_h_valid, r_h_ok, r_i_valid, r_i_ok;
    logic signed [NUM_W-1:0] r_h_lo, r_h_hi, r_i_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_valid <= 1'b0;
            r_i_valid <= 1'b0;
        end else if (w_en) begin
            r_h_valid <= w_x_tag.valid;
            r_i_valid <= r_h_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_h_ok  <= w_x_tag.ok;
            r_h_lo  <= $signed({1'b0, w_res - w_x_tag.frac}) * w_lower;
            r_h_hi  <= $signed({1'b0, w_x_tag.frac}) * w_upper;
            r_i_ok  <= r_h_ok;
            r_i_num <= r_h_lo + r_h_hi;
        end
    end

    hbq_div u_div_height (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_divisor (w_res),
        .i_num     (r_i_num),
        .i_tag     ({r_i_valid, r_i_ok, {RES_W{1'b0}}}),
        .o_quot    (w_height),
        .o_tag     (w_y_tag)
    );

    // output register
    logic      r_out_valid;
    t_out_item r_out_data;

    assign w_en = !(w_y_tag.valid && r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en && w_y_tag.valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && w_y_tag.valid) begin
            r_out_data.height   <= w_y_tag.ok ? w_height : '0;
            r_out_data.in_range <= w_y_tag.ok;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
endmodule

>>> hdl/hbq_checker.sv
`timescale 1ns / 1ps
module hbq_checker
    import hbq_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data,
    input logic      pready
);
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result shown straight after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.in_range |-> o_out_data.height == '0)
        else $error("out of range query with nonzero height");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("register port not ready");
endmodule

bind heightfield_bilinear_height_query_unit hbq_checker u_hbq_checker (.*);
